// ----- rtl/pcm_pkg.sv -----
`timescale 1ns / 1ps

package pcm_pkg;

	// Item commands
	typedef enum logic [1:0] {
		CMD_LOAD_A   = 2'd0,
		CMD_LOAD_B   = 2'd1,
		CMD_MULTIPLY = 2'd2
	} cmd_t;

	// APB register indexes (paddr[2])
	localparam logic REG_DEGREE_A = 1'b0;
	localparam logic REG_DEGREE_B = 1'b1;

	localparam int DEG_W   = 5;
	localparam int KIDX_W  = 6;
	localparam int COEF_W  = 32;
	localparam int MUL_W   = 64;
	localparam int FRAC_W  = 16;
	localparam int TERM_W  = 48;
	localparam int ACC_W   = 54;
	localparam int PROD_W  = 48;

	localparam logic signed [ACC_W-1:0] ACC_SAT_HI = 54'sd140737488355327;
	localparam logic signed [ACC_W-1:0] ACC_SAT_LO = -54'sd140737488355328;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic              wr_a;
		logic              wr_b;
		logic              issue;
		logic              acc_clr;
		logic              emit;
		logic              emit_last;
		logic [KIDX_W-1:0] emit_index;
	} ctl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/pcm_ram.sv -----
`timescale 1ns / 1ps

module pcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/pcm_ctrl.sv -----
`timescale 1ns / 1ps

module pcm_ctrl import pcm_pkg::*; #(
	parameter int MAX_DEGREE = 31,
	parameter int AW = $clog2(MAX_DEGREE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        command,
	input  logic [DEG_W-1:0]  coeff_index,
	input  logic [DEG_W-1:0]  degree_a,
	input  logic [DEG_W-1:0]  degree_b,
	input  dp_status_t        status,
	output ctl_cmd_t          cmd,
	output logic [AW-1:0]     rd_addr_a,
	output logic [AW-1:0]     rd_addr_b
);

	localparam logic [DEG_W-1:0] MAXD = DEG_W'(MAX_DEGREE);

	state_t            state_q, state_d;
	logic [KIDX_W-1:0] k_q, k_d;
	logic [AW-1:0]     i_q, i_d;

	logic [DEG_W-1:0]  da, db;
	logic [KIDX_W-1:0] last_k, k_lo, k_hi, i_ext, b_idx;
	logic              idx_ok;

	// degrees above the store depth are used as the top index
	assign da     = (degree_a > MAXD) ? MAXD : degree_a;
	assign db     = (degree_b > MAXD) ? MAXD : degree_b;
	assign last_k = KIDX_W'(da) + KIDX_W'(db);
	assign k_lo   = (k_q > KIDX_W'(db)) ? (k_q - KIDX_W'(db)) : '0;
	assign k_hi   = (k_q < KIDX_W'(da)) ? k_q : KIDX_W'(da);
	assign i_ext  = KIDX_W'(i_q);
	assign b_idx  = k_q - i_ext;
	assign idx_ok = (coeff_index <= MAXD);

	assign rd_addr_a = i_q;
	assign rd_addr_b = b_idx[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			i_q     <= i_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		k_d            = k_q;
		i_d            = i_q;
		item_stall     = 1'b1;
		cmd.wr_a       = 1'b0;
		cmd.wr_b       = 1'b0;
		cmd.issue      = 1'b0;
		cmd.acc_clr    = 1'b0;
		cmd.emit       = 1'b0;
		cmd.emit_last  = (k_q == last_k);
		cmd.emit_index = k_q;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					case (command)
						CMD_LOAD_A: cmd.wr_a = idx_ok;
						CMD_LOAD_B: cmd.wr_b = idx_ok;
						CMD_MULTIPLY: begin
							k_d     = '0;
							state_d = ST_START;
						end
						default: ;
					endcase
				end
			end
			ST_START: begin
				cmd.acc_clr = 1'b1;
				i_d         = k_lo[AW-1:0];
				state_d     = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (i_ext == k_hi) begin
					state_d = ST_DRAIN;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (k_q == last_k) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_START;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/pcm_datapath.sv -----
`timescale 1ns / 1ps

module pcm_datapath import pcm_pkg::*; #(
	parameter int MAX_DEGREE = 31,
	parameter int AW = $clog2(MAX_DEGREE + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_cmd_t                 cmd,
	input  logic [AW-1:0]            rd_addr_a,
	input  logic [AW-1:0]            rd_addr_b,
	input  logic [DEG_W-1:0]         coeff_index,
	input  logic signed [COEF_W-1:0] coeff_value,
	output dp_status_t               status,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [PROD_W-1:0] product_value,
	output logic [KIDX_W-1:0]        product_index,
	output logic                     last_coeff
);

	localparam int DEPTH = MAX_DEGREE + 1;

	logic [COEF_W-1:0]        a_s1, b_s1;
	logic                     v_s1_q, v_s2_q;
	logic signed [MUL_W-1:0]  p_s2;
	logic signed [TERM_W-1:0] term;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] sat;

	logic                     out_valid_q;
	logic signed [PROD_W-1:0] out_value_q;
	logic [KIDX_W-1:0]        out_index_q;
	logic                     out_last_q;

	pcm_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (coeff_index[AW-1:0]),
		.wdata (coeff_value),
		.raddr (rd_addr_a),
		.rdata (a_s1)
	);

	pcm_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (coeff_index[AW-1:0]),
		.wdata (coeff_value),
		.raddr (rd_addr_b),
		.rdata (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= cmd.issue;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= $signed(a_s1) * $signed(b_s1);
	end

	// Q32.32 -> Q32.16, floor
	assign term = p_s2[MUL_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2_q) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	always_comb begin
		if (acc_q > ACC_SAT_HI) begin
			sat = ACC_SAT_HI[PROD_W-1:0];
		end else if (acc_q < ACC_SAT_LO) begin
			sat = ACC_SAT_LO[PROD_W-1:0];
		end else begin
			sat = acc_q[PROD_W-1:0];
		end
	end

	assign status.pipe_busy = v_s1_q | v_s2_q;
	assign status.out_free  = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= sat;
			out_index_q <= cmd.emit_index;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign product_value = out_value_q;
	assign product_index = out_index_q;
	assign last_coeff    = out_last_q;

endmodule

// ----- rtl/poly_coefficient_multiply.sv -----
`timescale 1ns / 1ps

// Polynomial multiplier (linear convolution of two coefficient vectors).
// Coefficients of A and B are loaded one per transfer (command load A / load B,
// with their index); loads give no result, and a load with an index above
// MAX_DEGREE is dropped. A multiply transfer then emits degree_a+degree_b+1
// product coefficients in index order, the final one flagged by last_coeff.
// Each term a[i]*b[j] is Q16.16 x Q16.16, floored to Q32.16, summed in a
// 54-bit accumulator and saturated to 48 bits. Input is stalled for the whole
// run, which also waits on any output stall. Each term goes through the single
// shared multiplier, fed by one read port per coefficient store. Degrees above
// MAX_DEGREE are treated as MAX_DEGREE. Coefficients must be loaded before a
// multiply uses them; stores are not cleared by reset.

module poly_coefficient_multiply import pcm_pkg::*; #(
	parameter int MAX_DEGREE = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// APB config: degree_a at 0x0, degree_b at 0x4
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,

	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               command,
	input  logic [4:0]               coeff_index,
	input  logic signed [31:0]       coeff_value,

	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [47:0]       product_value,
	output logic [5:0]               product_index,
	output logic                     last_coeff
);

	localparam int AW = $clog2(MAX_DEGREE + 1);

	logic [DEG_W-1:0] degree_a_q, degree_b_q;
	logic             cfg_wr;

	ctl_cmd_t         ctl_cmd;
	dp_status_t       dp_status;
	logic [AW-1:0]    rd_addr_a, rd_addr_b;

	// Config registers; pready is tied high, so no access has wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_a_q <= '0;
			degree_b_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DEGREE_A: degree_a_q <= pwdata[DEG_W-1:0];
				REG_DEGREE_B: degree_b_q <= pwdata[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEGREE_A: prdata = 32'(degree_a_q);
			REG_DEGREE_B: prdata = 32'(degree_b_q);
			default:      prdata = '0;
		endcase
	end

	// Sequencer: loads in idle, then per coefficient clear / issue / drain / emit
	pcm_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.command     (command),
		.coeff_index (coeff_index),
		.degree_a    (degree_a_q),
		.degree_b    (degree_b_q),
		.status      (dp_status),
		.cmd         (ctl_cmd),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b)
	);

	// Stores, read -> multiply -> accumulate pipe, saturation, output register
	pcm_datapath #(.MAX_DEGREE(MAX_DEGREE)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.coeff_index   (coeff_index),
		.coeff_value   (coeff_value),
		.status        (dp_status),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.product_value (product_value),
		.product_index (product_index),
		.last_coeff    (last_coeff)
	);

`ifndef ASSERT_OFF
	// A multiply transfer locks the item channel on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && command == CMD_MULTIPLY) |=> item_stall)
		else $error("item channel open right after multiply");

	// No MAC work in flight while items are being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !dp_status.pipe_busy)
		else $error("MAC pipe busy while idle");

	// The output register is only loaded when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.emit |-> dp_status.out_free)
		else $error("emit into an occupied output register");

	// Emission happens only after the MAC pipe has drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.emit |-> !dp_status.pipe_busy)
		else $error("emit before accumulation finished");
`endif

endmodule
